// ===== rtl/core/html_entity_escaper_top_macros.svh =====
// ----------------------------------------------------------------------------
// html_entity_escaper_top_macros.svh
// Assertion macros shared by the entity escaper RTL.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_ESCAPER_TOP_MACROS_SVH
`define HTML_ENTITY_ESCAPER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// hee_pkg
// Types, character codes and entity lookup for the HTML entity escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hee_pkg;

  localparam int RUN_MAX   = 8;
  localparam int NAME_MAX  = 6;
  localparam int NAME_BITS = NAME_MAX * 8;
  localparam int LEN_W     = $clog2(RUN_MAX + 1);
  localparam int IDX_W     = $clog2(RUN_MAX);

  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] LATIN1_BASE  = 8'd160;
  localparam logic [7:0] NUMERIC_BASE = 8'd128;

  // Register byte addresses
  localparam logic [1:0] ADDR_SPECIAL_ONLY = 2'd0;

  typedef logic [NAME_BITS-1:0] name_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] chars;
    logic [LEN_W-1:0]        len;
  } run_t;

  // Entity names are right-justified: first character in the highest used byte.
  function automatic name_t latin1_name(input logic [6:0] idx);
    name_t nm;
    case (idx)
      7'd0:  nm = NAME_BITS'("nbsp");
      7'd1:  nm = NAME_BITS'("iexcl");
      7'd2:  nm = NAME_BITS'("cent");
      7'd3:  nm = NAME_BITS'("pound");
      7'd4:  nm = NAME_BITS'("curren");
      7'd5:  nm = NAME_BITS'("yen");
      7'd6:  nm = NAME_BITS'("brvbar");
      7'd7:  nm = NAME_BITS'("sect");
      7'd8:  nm = NAME_BITS'("uml");
      7'd9:  nm = NAME_BITS'("copy");
      7'd10: nm = NAME_BITS'("ordf");
      7'd11: nm = NAME_BITS'("laquo");
      7'd12: nm = NAME_BITS'("not");
      7'd13: nm = NAME_BITS'("shy");
      7'd14: nm = NAME_BITS'("reg");
      7'd15: nm = NAME_BITS'("macr");
      7'd16: nm = NAME_BITS'("deg");
      7'd17: nm = NAME_BITS'("plusmn");
      7'd18: nm = NAME_BITS'("sup2");
      7'd19: nm = NAME_BITS'("sup3");
      7'd20: nm = NAME_BITS'("acute");
      7'd21: nm = NAME_BITS'("micro");
      7'd22: nm = NAME_BITS'("para");
      7'd23: nm = NAME_BITS'("middot");
      7'd24: nm = NAME_BITS'("cedil");
      7'd25: nm = NAME_BITS'("sup1");
      7'd26: nm = NAME_BITS'("ordm");
      7'd27: nm = NAME_BITS'("raquo");
      7'd28: nm = NAME_BITS'("frac14");
      7'd29: nm = NAME_BITS'("frac12");
      7'd30: nm = NAME_BITS'("frac34");
      7'd31: nm = NAME_BITS'("iquest");
      7'd32: nm = NAME_BITS'("Agrave");
      7'd33: nm = NAME_BITS'("Aacute");
      7'd34: nm = NAME_BITS'("Acirc");
      7'd35: nm = NAME_BITS'("Atilde");
      7'd36: nm = NAME_BITS'("Auml");
      7'd37: nm = NAME_BITS'("Aring");
      7'd38: nm = NAME_BITS'("AElig");
      7'd39: nm = NAME_BITS'("Ccedil");
      7'd40: nm = NAME_BITS'("Egrave");
      7'd41: nm = NAME_BITS'("Eacute");
      7'd42: nm = NAME_BITS'("Ecirc");
      7'd43: nm = NAME_BITS'("Euml");
      7'd44: nm = NAME_BITS'("Igrave");
      7'd45: nm = NAME_BITS'("Iacute");
      7'd46: nm = NAME_BITS'("Icirc");
      7'd47: nm = NAME_BITS'("Iuml");
      7'd48: nm = NAME_BITS'("ETH");
      7'd49: nm = NAME_BITS'("Ntilde");
      7'd50: nm = NAME_BITS'("Ograve");
      7'd51: nm = NAME_BITS'("Oacute");
      7'd52: nm = NAME_BITS'("Ocirc");
      7'd53: nm = NAME_BITS'("Otilde");
      7'd54: nm = NAME_BITS'("Ouml");
      7'd55: nm = NAME_BITS'("times");
      7'd56: nm = NAME_BITS'("Oslash");
      7'd57: nm = NAME_BITS'("Ugrave");
      7'd58: nm = NAME_BITS'("Uacute");
      7'd59: nm = NAME_BITS'("Ucirc");
      7'd60: nm = NAME_BITS'("Uuml");
      7'd61: nm = NAME_BITS'("Yacute");
      7'd62: nm = NAME_BITS'("THORN");
      7'd63: nm = NAME_BITS'("szlig");
      7'd64: nm = NAME_BITS'("agrave");
      7'd65: nm = NAME_BITS'("aacute");
      7'd66: nm = NAME_BITS'("acirc");
      7'd67: nm = NAME_BITS'("atilde");
      7'd68: nm = NAME_BITS'("auml");
      7'd69: nm = NAME_BITS'("aring");
      7'd70: nm = NAME_BITS'("aelig");
      7'd71: nm = NAME_BITS'("ccedil");
      7'd72: nm = NAME_BITS'("egrave");
      7'd73: nm = NAME_BITS'("eacute");
      7'd74: nm = NAME_BITS'("ecirc");
      7'd75: nm = NAME_BITS'("euml");
      7'd76: nm = NAME_BITS'("igrave");
      7'd77: nm = NAME_BITS'("iacute");
      7'd78: nm = NAME_BITS'("icirc");
      7'd79: nm = NAME_BITS'("iuml");
      7'd80: nm = NAME_BITS'("eth");
      7'd81: nm = NAME_BITS'("ntilde");
      7'd82: nm = NAME_BITS'("ograve");
      7'd83: nm = NAME_BITS'("oacute");
      7'd84: nm = NAME_BITS'("ocirc");
      7'd85: nm = NAME_BITS'("otilde");
      7'd86: nm = NAME_BITS'("ouml");
      7'd87: nm = NAME_BITS'("divide");
      7'd88: nm = NAME_BITS'("oslash");
      7'd89: nm = NAME_BITS'("ugrave");
      7'd90: nm = NAME_BITS'("uacute");
      7'd91: nm = NAME_BITS'("ucirc");
      7'd92: nm = NAME_BITS'("uuml");
      7'd93: nm = NAME_BITS'("yacute");
      7'd94: nm = NAME_BITS'("thorn");
      7'd95: nm = NAME_BITS'("yuml");
      default: nm = '0;
    endcase
    return nm;
  endfunction

  // Wrap a name as &name; in a run.
  function automatic run_t named_run(input name_t nm);
    run_t r;
    logic [LEN_W-1:0] nl;
    nl = '0;
    for (int i = 0; i < NAME_MAX; i++) begin
      if (nm[i*8 +: 8] != 8'h00) nl = nl + LEN_W'(1);
    end
    r.chars = '0;
    r.chars[0] = CH_AMP;
    for (int k = 1; k <= NAME_MAX; k++) begin
      if (LEN_W'(k) <= nl) r.chars[k] = nm[(int'(nl) - k) * 8 +: 8];
    end
    for (int k = 1; k < RUN_MAX; k++) begin
      if (LEN_W'(k) == nl + LEN_W'(1)) r.chars[k] = CH_SEMI;
    end
    r.len = nl + LEN_W'(2);
    return r;
  endfunction

  // Build the whole output run for one source byte.
  function automatic run_t build_run(input logic [7:0] b, input logic special_only);
    run_t r;
    logic [7:0] v;
    logic [3:0] tens;
    logic [7:0] ones;
    v    = b - 8'd100;
    tens = 4'd2;
    if (v >= 8'd30) tens = 4'd3;
    if (v >= 8'd40) tens = 4'd4;
    if (v >= 8'd50) tens = 4'd5;
    ones = v - 8'(tens) * 8'd10;
    r = '0;
    if (b == CH_QUOT) begin
      r = named_run(NAME_BITS'("quot"));
    end else if (b == CH_AMP) begin
      r = named_run(NAME_BITS'("amp"));
    end else if (b == CH_LT) begin
      r = named_run(NAME_BITS'("lt"));
    end else if (b == CH_GT) begin
      r = named_run(NAME_BITS'("gt"));
    end else if (!special_only && b >= LATIN1_BASE) begin
      r = named_run(latin1_name(7'(b - LATIN1_BASE)));
    end else if (!special_only && b >= NUMERIC_BASE) begin
      // 128..159: hundreds digit is always one
      r.chars[0] = CH_AMP;
      r.chars[1] = CH_HASH;
      r.chars[2] = CH_ONE;
      r.chars[3] = CH_ZERO + 8'(tens);
      r.chars[4] = CH_ZERO + ones;
      r.chars[5] = CH_SEMI;
      r.len      = LEN_W'(6);
    end else begin
      r.chars[0] = b;
      r.len      = LEN_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/html_entity_escaper_top.sv =====
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready/in_byte carries one source byte per
//   transaction. Output channel out_valid/out_ready carries one character
//   per transaction in out_char, with out_last_of_run high on the final
//   character produced for a source byte. An APB port (psel, penable,
//   pwrite, paddr, pwdata, prdata, pready) holds special_only at address 0.
//   An accepted byte passes from the input register into the run register,
//   which offers its run one character at a time: one for a plain byte, up
//   to eight for an entity; the character counter of the run register steps
//   through them. Plain text thus flows at one byte per cycle while the
//   receiver takes each character.
//   A one-entry input register accepts a byte while the run register still
//   waits on a stalled receiver; the run register holds its characters until
//   each is taken. Reset empties both registers and clears special_only to
//   full Latin-1 escaping.
// ----------------------------------------------------------------------------
// html_entity_escaper_top
// Byte-stream HTML entity escaper with one-entry input register and run
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "html_entity_escaper_top_macros.svh"

module html_entity_escaper_top
  import hee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             special_only_r;
  logic             pend_v_r;
  logic [7:0]       pend_byte_r;
  logic             run_v_r;
  run_t             run_r;
  logic [IDX_W-1:0] idx_r;

  logic load;
  logic out_fire;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SPECIAL_ONLY) ? {31'b0, special_only_r} : 32'b0;

  assign out_valid       = run_v_r;
  assign out_char        = run_r.chars[idx_r];
  assign out_last_of_run = ({1'b0, idx_r} == (run_r.len - LEN_W'(1)));
  assign out_fire        = out_valid && out_ready;

  // Move the pending byte in once the current run has gone out.
  assign load     = pend_v_r && (!run_v_r || (out_fire && out_last_of_run));
  assign in_ready = !pend_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_only_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SPECIAL_ONLY) begin
      special_only_r <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_v_r <= 1'b1;
    end else if (load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      run_v_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_fire && out_last_of_run) begin
      run_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (out_fire) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= build_run(pend_byte_r, special_only_r);
    end
  end

  `HEE_ASSERT(a_run_len_nonzero, run_v_r |-> (run_r.len != '0 && run_r.len <= LEN_W'(RUN_MAX)),
    "run length out of range")
  `HEE_ASSERT(a_idx_in_run, run_v_r |-> ({1'b0, idx_r} < run_r.len), "character index past run")
  `HEE_ASSERT(a_entity_ends_semi, (out_valid && out_last_of_run && run_r.len > LEN_W'(1))
    |-> (out_char == CH_SEMI), "entity run does not end in semicolon")
  `HEE_ASSERT(a_stall_holds_pend, !in_ready |-> (pend_v_r && run_v_r),
    "input stalled without a pending byte and busy run")
  `HEE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && in_ready),
    "registers not empty after reset")

endmodule
